[rtl/core/vector_normalize_top_macros.svh]
// Assertion macros used by the RTL that carries checks.
`ifndef VECTOR_NORMALIZE_TOP_MACROS_SVH
`define VECTOR_NORMALIZE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector_normalize check failed");

// The consequent must hold in the cycle after the antecedent.
`define VN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vector_normalize check failed");

`endif

[rtl/core/vnorm_pkg.sv]
package vnorm_pkg;

  localparam int COMP_W      = 32;
  localparam int SQ_W        = 2 * COMP_W;
  localparam int ROOT_W      = COMP_W;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int SQRT_REM_W  = ROOT_W + 4;
  localparam int Q_W         = 31;
  localparam int DIV_STAGES  = Q_W;
  localparam int NUM_LANES   = 3;
  localparam int ABS_DLY     = SQRT_STAGES + 2;
  localparam int SIDE_DLY    = SQRT_STAGES + DIV_STAGES + 3;
  localparam int TOTAL_DLY   = SQRT_STAGES + DIV_STAGES + 4;

  localparam logic signed [COMP_W-1:0] UNIT_ONE = 32'sd1073741824;
  localparam logic signed [COMP_W-1:0] UNIT_NEG_ONE = -32'sd1073741824;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [COMP_W-1:0] mag_t;
  typedef logic [Q_W-1:0] quo_t;

  typedef struct packed {
    logic [NUM_LANES-1:0] neg;
    logic                 zero;
  } side_t;

  function automatic mag_t abs_comp(input comp_t v);
    mag_t r;
    r = v[COMP_W-1] ? (~mag_t'(v) + mag_t'(1)) : mag_t'(v);
    return r;
  endfunction

endpackage

[rtl/core/vnorm_ifs.sv]
interface vnorm_in_if;
  logic            valid;
  logic            ready;
  logic signed [31:0] comp_x;
  logic signed [31:0] comp_y;
  logic signed [31:0] comp_z;
  modport source (output valid, output comp_x, output comp_y, output comp_z, input ready);
  modport sink (input valid, input comp_x, input comp_y, input comp_z, output ready);
endinterface

interface vnorm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] unit_x;
  logic signed [31:0] unit_y;
  logic signed [31:0] unit_z;
  logic [31:0]        magnitude;
  logic               zero_vector;
  modport source (output valid, output unit_x, output unit_y, output unit_z,
                  output magnitude, output zero_vector, input ready);
  modport sink (input valid, input unit_x, input unit_y, input unit_z,
                input magnitude, input zero_vector, output ready);
endinterface

[rtl/core/vnorm_sqrt.sv]
module vnorm_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [vnorm_pkg::SQ_W-1:0]     rad,
  output logic [vnorm_pkg::ROOT_W-1:0]   root
);

  logic [vnorm_pkg::SQRT_REM_W-1:0] rem_r  [vnorm_pkg::SQRT_STAGES];
  logic [vnorm_pkg::ROOT_W-1:0]     root_r [vnorm_pkg::SQRT_STAGES];
  logic [vnorm_pkg::SQ_W-1:0]       rad_r  [vnorm_pkg::SQRT_STAGES];

  for (genvar k = 0; k < vnorm_pkg::SQRT_STAGES; k++) begin : g_stage
    logic [vnorm_pkg::SQRT_REM_W-1:0] rem_in;
    logic [vnorm_pkg::ROOT_W-1:0]     root_in;
    logic [vnorm_pkg::SQ_W-1:0]       rad_in;
    logic [vnorm_pkg::SQRT_REM_W-1:0] cur;
    logic [vnorm_pkg::SQRT_REM_W-1:0] trial;
    logic                             ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_rest
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end

    always_comb begin
      cur   = {rem_in[vnorm_pkg::SQRT_REM_W-3:0], rad_in[vnorm_pkg::SQ_W-1 -: 2]};
      trial = vnorm_pkg::SQRT_REM_W'({root_in, 2'b01});
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (cur - trial) : cur;
        root_r[k] <= {root_in[vnorm_pkg::ROOT_W-2:0], ge};
        rad_r[k]  <= {rad_in[vnorm_pkg::SQ_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[vnorm_pkg::SQRT_STAGES-1];

endmodule

[rtl/core/vnorm_div.sv]
module vnorm_div (
  input  logic                       clk,
  input  logic                       en,
  input  vnorm_pkg::mag_t            num,
  input  vnorm_pkg::mag_t            den,
  output vnorm_pkg::quo_t            quo
);

  vnorm_pkg::mag_t rem_r [vnorm_pkg::DIV_STAGES];
  vnorm_pkg::mag_t den_r [vnorm_pkg::DIV_STAGES];
  vnorm_pkg::quo_t q_r   [vnorm_pkg::DIV_STAGES];

  for (genvar j = 0; j < vnorm_pkg::DIV_STAGES; j++) begin : g_stage
    vnorm_pkg::mag_t              rem_in;
    vnorm_pkg::mag_t              den_in;
    vnorm_pkg::quo_t              q_in;
    logic                         bit_in;
    logic [vnorm_pkg::COMP_W:0]   cur;
    logic                         ge;

    if (j == 0) begin : g_first
      assign rem_in = {1'b0, num[vnorm_pkg::COMP_W-1:1]};
      assign den_in = den;
      assign q_in   = '0;
      assign bit_in = num[0];
    end else begin : g_rest
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
      assign bit_in = 1'b0;
    end

    always_comb begin
      cur = {rem_in, bit_in};
      ge  = (cur >= {1'b0, den_in});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? vnorm_pkg::COMP_W'(cur - {1'b0, den_in})
                       : vnorm_pkg::COMP_W'(cur);
        den_r[j] <= den_in;
        q_r[j]   <= {q_in[vnorm_pkg::Q_W-2:0], ge};
      end
    end
  end

  assign quo = q_r[vnorm_pkg::DIV_STAGES-1];

endmodule

[rtl/core/vnorm_merge.sv]
module vnorm_merge (
  input  logic                                         clk,
  input  logic                                         en,
  input  logic [vnorm_pkg::NUM_LANES-1:0][vnorm_pkg::Q_W-1:0] quo,
  input  vnorm_pkg::side_t                             side,
  input  vnorm_pkg::mag_t                              len,
  output vnorm_pkg::comp_t                             unit_x_r,
  output vnorm_pkg::comp_t                             unit_y_r,
  output vnorm_pkg::comp_t                             unit_z_r,
  output vnorm_pkg::mag_t                              magnitude_r,
  output logic                                         zero_vector_r
);

  vnorm_pkg::comp_t unit_nxt [vnorm_pkg::NUM_LANES];

  always_comb begin
    for (int i = 0; i < vnorm_pkg::NUM_LANES; i++) begin
      if (side.zero) begin
        unit_nxt[i] = '0;
      end else if (side.neg[i]) begin
        unit_nxt[i] = -$signed(vnorm_pkg::COMP_W'(quo[i]));
      end else begin
        unit_nxt[i] = $signed(vnorm_pkg::COMP_W'(quo[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_x_r      <= unit_nxt[0];
      unit_y_r      <= unit_nxt[1];
      unit_z_r      <= unit_nxt[2];
      magnitude_r   <= side.zero ? '0 : len;
      zero_vector_r <= side.zero;
    end
  end

endmodule

[rtl/core/vector_normalize_top.sv]
// Normalizes one signed Q16.16 vector (x, y, z) per transfer into a signed Q1.30 unit vector
// and an unsigned Q16.16 length; a zero vector gives all zeros with zero_vector set. A new
// vector is accepted every cycle while the result side keeps up. Each result passes through
// the absolute value, squaring and summing registers, then the bit-per-stage square root
// pipeline, then the three divider lanes that work side by side, and last the merge register.
// When a result waits at the output, the whole pipeline holds, empty stages included, and no
// input is taken until that result leaves.
module vector_normalize_top (
  input  logic        clk,
  input  logic        rst_n,
  vnorm_in_if.sink    in_ch,
  vnorm_out_if.source out_ch
);

  logic en;

  logic                         vld_r   [vnorm_pkg::TOTAL_DLY];
  vnorm_pkg::side_t             side_r  [vnorm_pkg::SIDE_DLY];
  vnorm_pkg::mag_t              abs_r   [vnorm_pkg::NUM_LANES];
  logic [vnorm_pkg::SQ_W-1:0]   sq_r    [vnorm_pkg::NUM_LANES];
  logic [vnorm_pkg::SQ_W-1:0]   sum_r;
  vnorm_pkg::mag_t              abs_dl_r [vnorm_pkg::ABS_DLY][vnorm_pkg::NUM_LANES];
  vnorm_pkg::mag_t              len_dl_r [vnorm_pkg::DIV_STAGES];
  vnorm_pkg::mag_t              root;
  logic [vnorm_pkg::NUM_LANES-1:0][vnorm_pkg::Q_W-1:0] quo;
  vnorm_pkg::side_t             side_nxt;
  logic                         zero_clean;
  logic                         units_in_range;

  assign en          = !vld_r[vnorm_pkg::TOTAL_DLY-1] || out_ch.ready;
  assign in_ch.ready = rst_n && en;

  always_comb begin
    side_nxt.neg  = {in_ch.comp_z[vnorm_pkg::COMP_W-1], in_ch.comp_y[vnorm_pkg::COMP_W-1],
                     in_ch.comp_x[vnorm_pkg::COMP_W-1]};
    side_nxt.zero = (in_ch.comp_x == '0) && (in_ch.comp_y == '0) && (in_ch.comp_z == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vnorm_pkg::TOTAL_DLY; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < vnorm_pkg::TOTAL_DLY; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abs_r[0] <= vnorm_pkg::abs_comp(in_ch.comp_x);
      abs_r[1] <= vnorm_pkg::abs_comp(in_ch.comp_y);
      abs_r[2] <= vnorm_pkg::abs_comp(in_ch.comp_z);
      side_r[0] <= side_nxt;
      for (int i = 1; i < vnorm_pkg::SIDE_DLY; i++) begin
        side_r[i] <= side_r[i-1];
      end
      for (int l = 0; l < vnorm_pkg::NUM_LANES; l++) begin
        sq_r[l]        <= abs_r[l] * abs_r[l];
        abs_dl_r[0][l] <= abs_r[l];
        for (int i = 1; i < vnorm_pkg::ABS_DLY; i++) begin
          abs_dl_r[i][l] <= abs_dl_r[i-1][l];
        end
      end
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
      len_dl_r[0] <= root;
      for (int i = 1; i < vnorm_pkg::DIV_STAGES; i++) begin
        len_dl_r[i] <= len_dl_r[i-1];
      end
    end
  end

  vnorm_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sum_r),
    .root (root)
  );

  for (genvar l = 0; l < vnorm_pkg::NUM_LANES; l++) begin : g_lane
    vnorm_div u_div (
      .clk (clk),
      .en  (en),
      .num (abs_dl_r[vnorm_pkg::ABS_DLY-1][l]),
      .den (root),
      .quo (quo[l])
    );
  end

  vnorm_merge u_merge (
    .clk           (clk),
    .en            (en),
    .quo           (quo),
    .side          (side_r[vnorm_pkg::SIDE_DLY-1]),
    .len           (len_dl_r[vnorm_pkg::DIV_STAGES-1]),
    .unit_x_r      (out_ch.unit_x),
    .unit_y_r      (out_ch.unit_y),
    .unit_z_r      (out_ch.unit_z),
    .magnitude_r   (out_ch.magnitude),
    .zero_vector_r (out_ch.zero_vector)
  );

  assign out_ch.valid = vld_r[vnorm_pkg::TOTAL_DLY-1];

  always_comb begin
    zero_clean = (out_ch.magnitude == '0) && (out_ch.unit_x == '0) &&
                 (out_ch.unit_y == '0) && (out_ch.unit_z == '0);
    units_in_range = ($signed(out_ch.unit_x) <= vnorm_pkg::UNIT_ONE) &&
                     ($signed(out_ch.unit_x) >= vnorm_pkg::UNIT_NEG_ONE) &&
                     ($signed(out_ch.unit_y) <= vnorm_pkg::UNIT_ONE) &&
                     ($signed(out_ch.unit_y) >= vnorm_pkg::UNIT_NEG_ONE) &&
                     ($signed(out_ch.unit_z) <= vnorm_pkg::UNIT_ONE) &&
                     ($signed(out_ch.unit_z) >= vnorm_pkg::UNIT_NEG_ONE);
  end

`include "vector_normalize_top_macros.svh"

  `VN_ASSERT_NOW(a_zero_clears, out_ch.valid && out_ch.zero_vector, zero_clean)
  `VN_ASSERT_NOW(a_len_nonzero, out_ch.valid && !out_ch.zero_vector, out_ch.magnitude != '0)
  `VN_ASSERT_NOW(a_unit_range, out_ch.valid, units_in_range)
  `VN_ASSERT_NEXT(a_pipe_drains, vld_r[vnorm_pkg::TOTAL_DLY-2] && en, out_ch.valid)

endmodule

[sim/vector_normalize_top_test.sv]
module vector_normalize_top_test;
  import vnorm_pkg::*;

  typedef struct {
    comp_t unit_x;
    comp_t unit_y;
    comp_t unit_z;
    mag_t  magnitude;
    logic  zero_vector;
  } unit_vec_t;

  class unit_vec_scoreboard;
    unit_vec_t pending_q[$];
    int        fail_count;

    function new();
      fail_count = 0;
    endfunction

    static function mag_t floor_root(logic [63:0] v);
      mag_t        root;
      mag_t        trial;
      logic [63:0] sq;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
        trial = root | (mag_t'(1) << i);
        sq = 64'(trial) * 64'(trial);
        if (sq <= v) begin
          root = trial;
        end
      end
      return root;
    endfunction

    static function comp_t scaled_quotient(comp_t c, mag_t len);
      logic [63:0] a;
      logic [63:0] q;
      a = c[31] ? 64'(-64'(signed'(c))) : 64'(c);
      q = (a << 30) / 64'(len);
      if (c[31]) begin
        q = -q;
      end
      return comp_t'(q[31:0]);
    endfunction

    function void note_input(comp_t x, comp_t y, comp_t z);
      unit_vec_t   e;
      logic [63:0] ax;
      logic [63:0] ay;
      logic [63:0] az;
      mag_t        len;
      ax = x[31] ? 64'(-64'(signed'(x))) : 64'(x);
      ay = y[31] ? 64'(-64'(signed'(y))) : 64'(y);
      az = z[31] ? 64'(-64'(signed'(z))) : 64'(z);
      len = floor_root(ax * ax + ay * ay + az * az);
      if (len == 0) begin
        e = '{unit_x: '0, unit_y: '0, unit_z: '0, magnitude: '0, zero_vector: 1'b1};
      end else begin
        e.unit_x = scaled_quotient(x, len);
        e.unit_y = scaled_quotient(y, len);
        e.unit_z = scaled_quotient(z, len);
        e.magnitude = len;
        e.zero_vector = 1'b0;
      end
      pending_q.push_back(e);
    endfunction

    function void check_result(comp_t ux, comp_t uy, comp_t uz, mag_t m, logic zv);
      unit_vec_t e;
      if (pending_q.size() == 0) begin
        $error("result transfer with no input outstanding");
        fail_count++;
        return;
      end
      e = pending_q.pop_front();
      if (ux !== e.unit_x) begin
        $error("unit_x expected %0d actual %0d", e.unit_x, ux);
        fail_count++;
      end
      if (uy !== e.unit_y) begin
        $error("unit_y expected %0d actual %0d", e.unit_y, uy);
        fail_count++;
      end
      if (uz !== e.unit_z) begin
        $error("unit_z expected %0d actual %0d", e.unit_z, uz);
        fail_count++;
      end
      if (m !== e.magnitude) begin
        $error("magnitude expected %0d actual %0d", e.magnitude, m);
        fail_count++;
      end
      if (zv !== e.zero_vector) begin
        $error("zero_vector expected %0d actual %0d", e.zero_vector, zv);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic no_idle;
  int   results_seen;

  vnorm_in_if  in_ch();
  vnorm_out_if out_ch();

  unit_vec_scoreboard sb;

  vector_normalize_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10000000;
    $display("[vector_normalize_top] ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_input(in_ch.comp_x, in_ch.comp_y, in_ch.comp_z);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.unit_x, out_ch.unit_y, out_ch.unit_z,
                      out_ch.magnitude, out_ch.zero_vector);
      results_seen++;
    end
  end

  initial begin
    int  gap;
    bit  long_hold_done;
    long_hold_done = 0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (1) begin
      if (!long_hold_done && results_seen >= 600) begin
        long_hold_done = 1;
        out_ch.ready <= 1'b0;
        for (int i = 0; i < 300; i++) begin
          @(posedge clk);
        end
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_vec(comp_t x, comp_t y, comp_t z);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.comp_x <= x;
    in_ch.comp_y <= y;
    in_ch.comp_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic comp_t rand_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return comp_t'($urandom());
    end else if (r < 8) begin
      return comp_t'($urandom()) >>> $urandom_range(0, 31);
    end else if (r < 9) begin
      return '0;
    end
    return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
  endfunction

  initial begin
    comp_t dir_vecs[$][3];
    int    waited;
    sb = new();
    results_seen = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.comp_x = '0;
    in_ch.comp_y = '0;
    in_ch.comp_z = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero vector, exact axis vectors, the most negative and positive patterns, and small and mixed vectors.
    dir_vecs = '{
      '{32'sd0, 32'sd0, 32'sd0},
      '{32'sd65536, 32'sd0, 32'sd0},
      '{32'sd0, -32'sd65536, 32'sd0},
      '{32'sd0, 32'sd0, 32'sd1},
      '{32'sh80000000, 32'sd0, 32'sd0},
      '{32'sd0, 32'sh80000000, 32'sd0},
      '{32'sd0, 32'sd0, 32'sh80000000},
      '{32'sh7fffffff, 32'sd0, 32'sd0},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000},
      '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
      '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff},
      '{32'sd1, 32'sd1, 32'sd1},
      '{-32'sd1, 32'sd0, 32'sd0},
      '{-32'sd1, -32'sd1, -32'sd1},
      '{32'sd196608, 32'sd262144, 32'sd0},
      '{32'sd65536, 32'sd131072, -32'sd131072},
      '{32'shffffffff, 32'sh7fffffff, 32'sd0}
    };
    foreach (dir_vecs[i]) begin
      send_vec(dir_vecs[i][0], dir_vecs[i][1], dir_vecs[i][2]);
    end

    for (int n = 0; n < 2000; n++) begin
      if (n % 250 == 0) begin
        no_idle = ($urandom_range(0, 2) == 0);
      end
      send_vec(rand_comp(), rand_comp(), rand_comp());
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (sb.pending_q.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);

    if (sb.fail_count == 0 && sb.pending_q.size() == 0) begin
      $display("[vector_normalize_top] OK");
    end else begin
      $display("[vector_normalize_top] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/vnorm_pkg.sv
rtl/core/vnorm_ifs.sv
rtl/core/vnorm_sqrt.sv
rtl/core/vnorm_div.sv
rtl/core/vnorm_merge.sv
rtl/core/vector_normalize_top.sv
sim/vector_normalize_top_test.sv
